@@ sv/mtcc_pkg.sv @@
`timescale 1ns / 1ps

package mtcc_pkg;

    localparam int WORD_W      = 32;
    localparam int NUM_PERMS   = 24;
    localparam int CELLS       = 16;
    localparam int SYMBOLS     = 4;
    localparam int LT_W        = NUM_PERMS - 1;   // identity skipped
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_TDATA_W = 40;              // 33 bits of fields, padded to bytes

    // All relabelings of {0,1,2,3}; entry 0 is the identity.
    localparam logic [1:0] PERM_TAB [NUM_PERMS][SYMBOLS] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3, 2'd2},
        '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd0, 2'd3, 2'd1, 2'd2}, '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd1, 2'd2, 2'd3, 2'd0},
        '{2'd1, 2'd3, 2'd0, 2'd2}, '{2'd1, 2'd3, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd2, 2'd0, 2'd3, 2'd1},
        '{2'd2, 2'd1, 2'd0, 2'd3}, '{2'd2, 2'd1, 2'd3, 2'd0},
        '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd2, 2'd3, 2'd1, 2'd0},
        '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd0, 2'd2, 2'd1},
        '{2'd3, 2'd1, 2'd0, 2'd2}, '{2'd3, 2'd1, 2'd2, 2'd0},
        '{2'd3, 2'd2, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    // Word with its per-relabeling "smaller" flags.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [LT_W-1:0]   lt;
    } t_item;

    // Relabel a table: value v at (r,c) becomes s(v) at (s(r),s(c)).
    // Pure rewiring plus a 4-entry substitution per cell.
    function automatic logic [WORD_W-1:0] relabel(input logic [WORD_W-1:0] w,
                                                 input int k);
        logic [WORD_W-1:0] res;
        logic [1:0]        v;
        logic [3:0]        dest;
        res = '0;
        for (int pos = 0; pos < CELLS; pos++) begin
            v    = w[2*pos +: 2];
            dest = {PERM_TAB[k][pos >> 2], PERM_TAB[k][pos & 3]};
            res[2*dest +: 2] = PERM_TAB[k][v];
        end
        return res;
    endfunction

endpackage

@@ sv/magma_table_canonical_check_unit.sv @@
`timescale 1ns / 1ps

// Canonical-form check for 4x4 operation tables. Each input item is one 32-bit
// table, 2-bit cell (r,c) at bits 2*(4r+c). The unit applies all 23 non-identity
// relabelings of {0,1,2,3} in parallel and flags the table when none of them
// yields a smaller unsigned word, i.e. the table is the least of its
// isomorphism class. Throughput is one item per clock while the master side
// accepts results, with no dependence between items. From input acceptance to
// the master side, an item passes the classification register, the queue, and
// the output register. The queue (QUEUE_DEPTH items) lets the input side keep
// running while a result waits on the output. No configuration, no stored state.
module magma_table_canonical_check_unit #(
    parameter int QUEUE_DEPTH = mtcc_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mtcc_pkg::WORD_W-1:0]       s_axis_tdata,   // [31:0] table_word
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mtcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // [31:0] table_echo,
                                                              // [32] is_smallest,
                                                              // [39:33] zero
);

    // front -> queue
    logic            fq_valid;
    logic            fq_ready;
    mtcc_pkg::t_item fq_item;
    // queue -> back
    logic            qb_valid;
    logic            qb_ready;
    mtcc_pkg::t_item qb_item;

    // Relabel and compare; registers the word with its 23 "smaller" flags.
    mtcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (s_axis_tdata),
        .o_valid (fq_valid),
        .i_ready (fq_ready),
        .o_item  (fq_item)
    );

    mtcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item)
    );

    // Verdict = no flag set; packed into the output register.
    mtcc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (qb_valid),
        .o_ready  (qb_ready),
        .i_item   (qb_item),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule

@@ sv/mtcc_front.sv @@
`timescale 1ns / 1ps

// Accepts a word, builds all relabeled words and compares each with it.
module mtcc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mtcc_pkg::WORD_W-1:0]  i_word,
    output logic                         o_valid,
    input  logic                         i_ready,
    output mtcc_pkg::t_item              o_item
);

    logic [mtcc_pkg::LT_W-1:0] lt;
    logic                      r_valid;
    mtcc_pkg::t_item           r_item;
    logic                      load;

    for (genvar k = 1; k < mtcc_pkg::NUM_PERMS; k++) begin : g_cmp
        assign lt[k-1] = (mtcc_pkg::relabel(i_word, k) < i_word);
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (load) begin
            r_item.word <= i_word;
            r_item.lt   <= lt;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // A stalled stage keeps its item.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_item))
        else $error("front stage lost or changed a stalled item");

endmodule

@@ sv/mtcc_queue.sv @@
`timescale 1ns / 1ps

// Small FIFO between classification and result stage.
module mtcc_queue #(
    parameter int DEPTH = mtcc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mtcc_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output mtcc_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mtcc_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue fill did not follow a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

endmodule

@@ sv/mtcc_back.sv @@
`timescale 1ns / 1ps

// Reduces the comparison flags to the verdict and holds the result item.
module mtcc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  mtcc_pkg::t_item                   i_item,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [mtcc_pkg::OUT_TDATA_W-1:0]  o_tdata
);

    localparam int PAD_W = mtcc_pkg::OUT_TDATA_W - mtcc_pkg::WORD_W - 1;

    logic                               r_valid;
    logic [mtcc_pkg::OUT_TDATA_W-1:0]   r_tdata;

    assign o_ready = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_tdata <= {{PAD_W{1'b0}}, ~(|i_item.lt), i_item.word};
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_tdata[mtcc_pkg::OUT_TDATA_W-1 -: PAD_W] == '0))
        else $error("pad bits of result not zero");

endmodule
